[src/polyline_point_at_arc_assert.svh]
// Assertion macros used by the polyline point-at-arc back module.
`ifndef POLYLINE_POINT_AT_ARC_ASSERT_SVH
`define POLYLINE_POINT_AT_ARC_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PPA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PPA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

[src/ppa_pkg.sv]
// Shared types and constants for the polyline point-at-arc block.
package ppa_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] REG_TOTAL_LENGTH = 2'd1;
    localparam logic [1:0] REG_MIN_SEGMENT  = 2'd2;

    // Query item passed from front to back.
    typedef struct packed {
        logic signed [31:0] arc;
    } query_t;

endpackage

[src/ppa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module ppa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/ppa_front.sv]
// Front: accepts items, forwards loads to storage and queries to the queue.
module ppa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic signed [31:0]  arc_position,
    output logic                load_en,
    output logic                q_valid,
    output ppa_pkg::query_t     q_data,
    input  logic                q_ready,
    input  logic                back_busy
);

    logic            full_reg, full_next;
    ppa_pkg::query_t data_reg;

    // One-entry queue toward the back part; loads wait while a query reads storage
    assign in_stall = full_reg || (back_busy && operation == ppa_pkg::OP_LOAD);
    assign load_en  = in_valid && !in_stall && (operation == ppa_pkg::OP_LOAD);
    assign q_valid  = full_reg;
    assign q_data   = data_reg;

    always_comb
    begin
        full_next = full_reg;
        if (full_reg && q_ready)
        begin
            full_next = 1'b0;
        end
        if (in_valid && !full_reg && operation == ppa_pkg::OP_QUERY)
        begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !full_reg)
        begin
            data_reg.arc <= arc_position;
        end
    end

endmodule

[src/ppa_back.sv]
// Back: scans lengths, divides serially and interpolates one query.
`include "polyline_point_at_arc_assert.svh"
module ppa_back #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  ppa_pkg::query_t                q_data,
    output logic                           q_ready,
    output logic                           busy,
    input  logic [$clog2(MAX_SAMPLES):0]   count,
    input  logic [31:0]                    total_length,
    input  logic [15:0]                    min_seg,
    output logic [$clog2(MAX_SAMPLES)-1:0] rd_addr,
    input  logic [31:0]                    rd_x,
    input  logic [31:0]                    rd_y,
    input  logic [31:0]                    rd_len,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             point_x,
    output logic signed [31:0]             point_y
);

    localparam int AW = $clog2(MAX_SAMPLES);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD0   = 11'b00000000010,
        S_LD0   = 11'b00000000100,
        S_SCAN  = 11'b00000001000,
        S_CHK   = 11'b00000010000,
        S_DIV   = 11'b00000100000,
        S_RDA   = 11'b00001000000,
        S_LDA   = 11'b00010000000,
        S_MULX  = 11'b00100000000,
        S_MULY  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic signed [32:0]  arc_reg;
    logic [31:0]         lo_reg;
    logic [31:0]         seg_reg;
    logic [48:0]         rem_reg;
    logic [16:0]         t_reg;
    logic [4:0]          bit_reg;
    logic [31:0]         ax_reg, ay_reg;
    logic signed [32:0]  dx_reg, dy_reg;
    logic signed [50:0]  prod_reg;
    logic [31:0]         ox_reg, oy_reg;
    logic                direct_reg;
    logic                ov_reg;
    logic [AW:0]         n_w;
    logic [AW-1:0]       last_w;
    logic                far_w;
    logic signed [33:0]  seg_w;
    logic signed [33:0]  num_w;
    logic [48:0]         rem_sh;
    logic signed [50:0]  prod_w;
    logic signed [34:0]  res_w;

    assign n_w    = (count > (AW+1)'(MAX_SAMPLES)) ? (AW+1)'(MAX_SAMPLES) : count;
    assign last_w = AW'(n_w - 1'b1);
    assign q_ready = (state_reg == S_IDLE) && !ov_reg;
    assign busy = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign point_x = ox_reg;
    assign point_y = oy_reg;

    // Arc at or past the end length answers with the last sample
    assign far_w = (n_w > (AW+1)'(1)) && (arc_reg > 0)
                   && (arc_reg >= $signed({1'b0, total_length}));

    // Segment length and numerator; the numerator is clamped when it is stored
    assign seg_w = $signed({2'b0, rd_len}) - $signed({2'b0, lo_reg});
    assign num_w = arc_reg - $signed({2'b0, lo_reg});
    assign rem_sh = {rem_reg[47:0], 1'b0};
    // Blend product for the current coordinate
    assign prod_w = ((state_reg == S_MULX) ? dx_reg : dy_reg) * $signed({1'b0, t_reg});
    assign res_w = $signed({{3{(state_reg == S_OUT ? ay_reg[31] : ax_reg[31])}},
                   (state_reg == S_OUT ? ay_reg : ax_reg)}) + 35'(prod_reg >>> 16);

    always_comb
    begin
        rd_addr = idx_reg;
        unique case (state_reg)
            S_RD0:   rd_addr = far_w ? last_w : idx_reg;
            S_SCAN:  rd_addr = idx_reg + 1'b1;
            S_RDA:   rd_addr = idx_reg - 1'b1;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid && !ov_reg) state_next = S_RD0;
            S_RD0:   state_next = S_LD0;
            S_LD0:   state_next = direct_reg ? S_MULX : S_SCAN;
            S_SCAN:  state_next = S_CHK;
            S_CHK:   state_next = S_SCAN;
            S_DIV:   if (bit_reg == 5'd0) state_next = S_RDA;
            S_RDA:   state_next = S_LDA;
            S_LDA:   state_next = S_MULX;
            S_MULX:  state_next = S_MULY;
            S_MULY:  state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && q_valid && !ov_reg)
        begin
            idx_next = '0;
        end
        // Step to the end point of the next segment
        if (state_reg == S_SCAN)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (state_reg == S_CHK)
        begin
            if (arc_reg <= $signed({1'b0, rd_len}))
            begin
                state_next = (seg_w > $signed({18'b0, min_seg})) ? S_DIV : S_RDA;
            end
            else if (idx_reg == last_w)
            begin
                state_next = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (state_reg == S_OUT)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                arc_reg <= {q_data.arc[31], q_data.arc};
                t_reg   <= '0;
            end
            S_LD0:
            begin
                // Classify: direct answers skip the scan
                dx_reg <= '0;
                dy_reg <= '0;
                lo_reg <= rd_len;
                if (n_w == '0)
                begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                    ax_reg <= '0;
                    ay_reg <= '0;
                end
                else
                begin
                    ox_reg <= rd_x;
                    oy_reg <= rd_y;
                    ax_reg <= rd_x;
                    ay_reg <= rd_y;
                end
            end
            S_CHK:
            begin
                ox_reg  <= rd_x;
                oy_reg  <= rd_y;
                seg_reg <= seg_w[31:0];
                if (num_w < 0)
                begin
                    rem_reg <= '0;
                end
                else if (num_w > seg_w)
                begin
                    rem_reg <= {17'b0, seg_w[31:0]};
                end
                else
                begin
                    rem_reg <= {17'b0, num_w[31:0]};
                end
                bit_reg <= 5'd16;
                t_reg   <= '0;
                if (!(arc_reg <= $signed({1'b0, rd_len})))
                begin
                    lo_reg <= rd_len;
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                if (bit_reg == 5'd16)
                begin
                    if (rem_reg[31:0] >= seg_reg)
                    begin
                        t_reg   <= 17'h10000;
                        rem_reg <= '0;
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                    end
                end
                else if (rem_reg >= {17'b0, seg_reg})
                begin
                    t_reg[bit_reg] <= 1'b1;
                    rem_reg <= (rem_reg - {17'b0, seg_reg}) << 1;
                end
                else
                begin
                    rem_reg <= rem_sh;
                end
                if (bit_reg != 5'd0)
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
            S_LDA:
            begin
                ax_reg <= rd_x;
                ay_reg <= rd_y;
                dx_reg <= $signed({ox_reg[31], ox_reg}) - $signed({rd_x[31], rd_x});
                dy_reg <= $signed({oy_reg[31], oy_reg}) - $signed({rd_y[31], rd_y});
            end
            S_MULX:
            begin
                prod_reg <= prod_w;
            end
            S_MULY:
            begin
                ox_reg   <= res_w[31:0];
                prod_reg <= prod_w;
            end
            S_OUT:
            begin
                if (!direct_reg && idx_reg != '0 && t_reg != 17'h1ffff)
                begin
                    oy_reg <= res_w[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Direct cases never enter the scan; a scan with no segment found ends likewise
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD0)
        begin
            direct_reg <= (n_w <= (AW+1)'(1)) || (arc_reg <= 0)
                          || (arc_reg >= $signed({1'b0, total_length}));
        end
        else if (state_reg == S_LD0 && !(n_w <= (AW+1)'(1) || arc_reg <= 0)
                 && arc_reg >= $signed({1'b0, total_length}))
        begin
            direct_reg <= 1'b1;
        end
        else if (state_reg == S_CHK && !(arc_reg <= $signed({1'b0, rd_len}))
                 && idx_reg == last_w)
        begin
            direct_reg <= 1'b1;
        end
    end

    `PPA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, q_ready, state_reg == S_IDLE)
    `PPA_ASSERT_NEXT(a_out_after_done, clk, rst_n, state_reg == S_OUT, out_valid)
    `PPA_ASSERT_IMPL(a_t_range, clk, rst_n, state_reg == S_MULX, t_reg <= 17'h10000)

endmodule

[src/polyline_point_at_arc.sv]
// Polyline point-at-arc block: the time from a query's acceptance to a valid
// result is set by the length scan over the sample RAMs, with a read state and
// a check state per segment, and by the 17-step serial divider; answers that
// need no scan skip both. Loads are written in the cycle they are accepted but
// are held off while a query is being worked on.
// Results leave through a held output register while the next query queues.
module polyline_point_at_arc #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [5:0]          sample_index,
    input  logic signed [31:0]  sample_x,
    input  logic signed [31:0]  sample_y,
    input  logic [31:0]         cum_length,
    input  logic signed [31:0]  arc_position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  point_x,
    output logic signed [31:0]  point_y,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int AW = $clog2(MAX_SAMPLES);

    logic [6:0]              count_reg;
    logic [31:0]             total_reg;
    logic [15:0]             min_seg_reg;
    logic                    load_en, wr_en;
    logic                    q_valid, q_ready;
    logic                    back_busy;
    ppa_pkg::query_t         q_data;
    logic [AW-1:0]           rd_addr;
    logic [31:0]             rd_x, rd_y, rd_len;
    logic [AW:0]             count_w;

    assign cfg_ready = 1'b1;
    assign wr_en = load_en && ({26'b0, sample_index} < 32'(MAX_SAMPLES));
    assign count_w = ((AW+1) >= 7) ? (AW+1)'(count_reg)
                   : ((count_reg > 7'(MAX_SAMPLES)) ? (AW+1)'(MAX_SAMPLES)
                                                    : (AW+1)'(count_reg));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            min_seg_reg <= 16'd7;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ppa_pkg::REG_SAMPLE_COUNT: count_reg   <= cfg_data[6:0];
                ppa_pkg::REG_TOTAL_LENGTH: total_reg   <= cfg_data;
                ppa_pkg::REG_MIN_SEGMENT:  min_seg_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ppa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .arc_position(arc_position), .load_en(load_en),
        .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready),
        .back_busy(back_busy)
    );

    ppa_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram_x (
        .clk(clk), .wr_en(wr_en), .wr_addr(AW'(sample_index)), .wr_data(sample_x),
        .rd_addr(rd_addr), .rd_data(rd_x)
    );
    ppa_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram_y (
        .clk(clk), .wr_en(wr_en), .wr_addr(AW'(sample_index)), .wr_data(sample_y),
        .rd_addr(rd_addr), .rd_data(rd_y)
    );
    ppa_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram_len (
        .clk(clk), .wr_en(wr_en), .wr_addr(AW'(sample_index)), .wr_data(cum_length),
        .rd_addr(rd_addr), .rd_data(rd_len)
    );

    ppa_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_ready(q_ready), .busy(back_busy), .count(count_w),
        .total_length(total_reg), .min_seg(min_seg_reg), .rd_addr(rd_addr),
        .rd_x(rd_x), .rd_y(rd_y), .rd_len(rd_len), .out_valid(out_valid),
        .out_stall(out_stall), .point_x(point_x), .point_y(point_y)
    );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the polyline point-at-arc block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSAMP = 64;
    localparam int CYCLE_LIMIT = 1500000;

    // One input item as offered to the block
    typedef struct packed {
        logic        op;
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] len;
        logic [31:0] arc;
    } item_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic [5:0] sample_index = '0;
    logic signed [31:0] sample_x = '0;
    logic signed [31:0] sample_y = '0;
    logic [31:0] cum_length = '0;
    logic signed [31:0] arc_position = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    polyline_point_at_arc u_top (.*);

    // Predictor state
    logic [31:0] px_mem [NSAMP];
    logic [31:0] py_mem [NSAMP];
    logic [31:0] len_mem [NSAMP];
    logic [6:0] n_used;
    logic [31:0] edge_len;
    logic [15:0] min_seg;

    item_t pending_items[$];
    point_t expected_points[$];
    int errors = 0;
    int cycles = 0;
    bit hold_go = 1'b0;
    bit hold_on = 1'b0;

    initial forever #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("polyline_point_at_arc regression: fail");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Linear blend with floor of the scaled difference
    function automatic logic [31:0] blend_coord(logic [31:0] a, logic [31:0] b,
                                                longint t);
        longint av;
        longint d;
        longint p;
        longint q;
        av = longint'(signed'(a));
        d = longint'(signed'(b)) - av;
        p = d * t;
        if (p >= 0) q = p >>> 16;
        else q = -((-p + 65535) >>> 16);
        return 32'(av + q);
    endfunction

    // Point on the stored polyline at a given arc
    function automatic point_t point_at_arc(logic [31:0] arc_raw);
        point_t r;
        int n;
        longint arc;
        longint lo;
        longint hi;
        longint seg;
        longint num;
        longint t;
        n = (n_used > NSAMP) ? NSAMP : n_used;
        arc = longint'(signed'(arc_raw));
        if (n == 0) r = '0;
        else if (n == 1 || arc <= 0) r = '{px_mem[0], py_mem[0]};
        else
        begin
            r = '{px_mem[n-1], py_mem[n-1]};
            if (arc < longint'(edge_len))
            begin
                for (int i = 0; i + 1 < n; i++)
                begin
                    lo = longint'(len_mem[i]);
                    hi = longint'(len_mem[i+1]);
                    if (arc <= hi)
                    begin
                        seg = hi - lo;
                        t = 0;
                        if (seg > longint'(min_seg))
                        begin
                            num = arc - lo;
                            if (num < 0) num = 0;
                            if (num > seg) num = seg;
                            t = (num << 16) / seg;
                        end
                        r.px = blend_coord(px_mem[i], px_mem[i+1], t);
                        r.py = blend_coord(py_mem[i], py_mem[i+1], t);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // Driver: offer queued items with random gaps
    int gap_in = 0;
    always @(posedge clk)
    begin
        item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                it = pending_items.pop_front();
                if (it.op == ppa_pkg::OP_LOAD)
                begin
                    px_mem[it.idx] <= it.x;
                    py_mem[it.idx] <= it.y;
                    len_mem[it.idx] <= it.len;
                end
                else
                    expected_points.push_back(point_at_arc(it.arc));
                gap_in = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) gap_in = 0;
            end
            if (in_valid && in_stall)
                ;
            else if (gap_in > 0)
            begin
                gap_in--;
                in_valid <= 1'b0;
            end
            else if ((!in_valid || !in_stall) && pending_items.size() > 0 &&
                     !(in_valid && !in_stall && pending_items.size() == 0))
            begin
                it = pending_items[0];
                in_valid <= 1'b1;
                operation <= it.op;
                sample_index <= it.idx;
                sample_x <= it.x;
                sample_y <= it.y;
                cum_length <= it.len;
                arc_position <= it.arc;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted in cycles here
    initial
    begin
        wait (hold_go);
        hold_on <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Monitor and receiver stall
    int gap_out = 0;
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    report("unexpected result", point_x, point_y);
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (point_x !== e.px) report("point_x", point_x, e.px);
                    if (point_y !== e.py) report("point_y", point_y, e.py);
                end
                gap_out = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) gap_out = 0;
            end
            if (hold_on)
            begin
                out_stall <= 1'b1;
            end
            else if (gap_out > 0)
            begin
                gap_out--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            ppa_pkg::REG_SAMPLE_COUNT: n_used = val[6:0];
            ppa_pkg::REG_TOTAL_LENGTH: edge_len = val;
            ppa_pkg::REG_MIN_SEGMENT:  min_seg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic item_t load_item(int i, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] len);
        item_t it;
        it = '{ppa_pkg::OP_LOAD, 6'(i), x, y, len, $urandom()};
        return it;
    endfunction

    function automatic item_t query_item(logic [31:0] arc);
        item_t it;
        it = '{ppa_pkg::OP_QUERY, 6'($urandom()), $urandom(), $urandom(), $urandom(), arc};
        return it;
    endfunction

    // Load a polyline of n samples with ascending (mostly) lengths
    task automatic load_polyline(int n, int step_max);
        logic [31:0] len;
        len = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++)
        begin
            pending_items.push_back(load_item(i, $urandom(), $urandom(), len));
            if ($urandom_range(0, 15) == 0) len = len - $urandom_range(0, 200);
            else if ($urandom_range(0, 7) == 0) len = len + $urandom_range(0, 8);
            else len = len + $urandom_range(0, step_max);
        end
    endtask

    function automatic logic [31:0] rand_arc(logic [31:0] top);
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 5)) - 2;
            3: return $urandom();
            4: return top;
            default: return $urandom_range(0, top + 100);
        endcase
    endfunction

    int n;
    logic [31:0] top;
    initial
    begin
        n_used = 0;
        edge_len = 0;
        min_seg = 7;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty polyline, then extremes of one and two samples
        pending_items.push_back(query_item(32'd100));
        pending_items.push_back(load_item(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        pending_items.push_back(load_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(load_item(63, 32'h1234_5678, 32'hFFFF_0000, 32'd5));
        wait_idle();
        write_reg(ppa_pkg::REG_SAMPLE_COUNT, 7'd1);
        write_reg(ppa_pkg::REG_TOTAL_LENGTH, 32'hFFFF_FFFF);
        write_reg(ppa_pkg::REG_MIN_SEGMENT, 16'hFFFF);
        pending_items.push_back(query_item(32'd50));
        wait_idle();
        write_reg(ppa_pkg::REG_SAMPLE_COUNT, 7'd2);
        pending_items.push_back(query_item(32'h8000_0000));
        pending_items.push_back(query_item(32'd0));
        pending_items.push_back(query_item(32'h7FFF_FFFF));
        pending_items.push_back(query_item(32'h0001_0000));
        wait_idle();
        write_reg(ppa_pkg::REG_MIN_SEGMENT, 16'd0);
        write_reg(ppa_pkg::REG_TOTAL_LENGTH, 32'd0);
        pending_items.push_back(query_item(32'd1));
        wait_idle();
        write_reg(ppa_pkg::REG_TOTAL_LENGTH, 32'hFFFF_FFFF);
        pending_items.push_back(query_item(32'd1));
        pending_items.push_back(query_item(32'h7FFF_FFFF));
        pending_items.push_back(query_item(32'h4000_0000));
        wait_idle();

        // Long receiver hold-off so the block backs up
        hold_go = 1'b1;
        for (int i = 0; i < 20; i++) pending_items.push_back(query_item($urandom()));
        wait_idle();

        // Random phases
        for (int ph = 0; ph < 40; ph++)
        begin
            n = (ph % 8 == 0) ? NSAMP : $urandom_range(2, 12);
            load_polyline(n, (ph % 2) ? 32'h0002_0000 : 40);
            wait_idle();
            top = len_mem[n-1];
            write_reg(ppa_pkg::REG_SAMPLE_COUNT, (ph % 13 == 5) ? 7'd127 : 7'(n));
            if (ph % 13 == 5) n_used = 127;
            write_reg(ppa_pkg::REG_TOTAL_LENGTH, (ph % 5 == 0) ? $urandom() :
                      top + $urandom_range(0, 10) - 5);
            write_reg(ppa_pkg::REG_MIN_SEGMENT, (ph % 6 == 0) ? 16'hFFFF :
                      (ph % 6 == 1) ? 16'd0 : 16'($urandom_range(0, 30)));
            for (int q = 0; q < 35; q++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(load_item($urandom_range(0, n - 1),
                        $urandom(), $urandom(), $urandom_range(0, top + 50)));
                else
                    pending_items.push_back(query_item(rand_arc(top)));
            end
            wait_idle();
        end

        if (errors == 0)
            $display("polyline_point_at_arc regression: pass");
        else
            $display("polyline_point_at_arc regression: fail");
        $finish;
    end
endmodule
